@@ src/barometric_pressure_compensation_assert.svh @@
// ============================================================================
// Assertion macros for the barometric pressure compensation block
// Assertion wrappers that can be compiled out for synthesis.
// ============================================================================
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_ASSERT_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_ASSERT_SVH
`ifndef SYNTH
`define BPC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bpc assertion failed");
`define BPC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("bpc assertion failed");
`else
`define BPC_ASSERT(label, clk, rst_n, prop)
`define BPC_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ src/bpc_pkg.sv @@
// ============================================================================
// Barometric pressure compensation package
// Shared types and constants of the compensation pipeline.
// ============================================================================
package bpc_pkg;

    typedef enum logic [2:0] {
        CFG_CAL_A_SIGNED   = 3'd0,
        CFG_CAL_A_UNSIGNED = 3'd1,
        CFG_CAL_B_PAIR     = 3'd2,
        CFG_CAL_M_PAIR     = 3'd3,
        CFG_OVERSAMPLING   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic        div_error;
        logic [31:0] pressure_pa;
        logic [15:0] temp_tenths;
    } t_result;

    localparam logic [31:0] C_B6_OFFSET = 32'd4000;
    localparam logic [31:0] C_B4_BIAS   = 32'd32768;
    localparam logic [15:0] C_P_SCALE   = 16'd50000;
    localparam logic [31:0] C_P_C1      = 32'd3038;
    localparam logic [31:0] C_P_C2      = 32'hFFFF_E343;
    localparam logic [31:0] C_P_C3      = 32'd3791;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

@@ src/barometric_pressure_compensation.sv @@
// ============================================================================
// Barometric pressure compensation
// Integer temperature and pressure compensation in a deep pipeline.
// ============================================================================
// The slave stream takes one word per item: raw_temp and raw_pressure.
// The master stream returns temp_tenths and pressure_pa in tdata and the
// divide error flag in tuser; results then read as zero. Calibration words
// and the oversampling setting are written through the configuration
// channel, which is always ready; the user must write them only while the
// block is idle, and the block does not enforce this. A new word can be
// accepted in every cycle while the skid stage is empty. Stages: four setup,
// a 27-stage temperature divider, nine of products and sums, a 32-stage
// pressure divider, four of the final polynomial and the output register.
// Reset clears every valid bit and loads the calibration registers with
// zero and the oversampling setting with three.
// When the receiver stalls, one result waits in the output register and
// one more in a skid stage; only then does the whole pipeline hold, and
// o_s_tready drops until the skid stage has drained.
// ============================================================================
module barometric_pressure_compensation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // raw_temp[15:0], raw_pressure[34:16], zero pad
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // temp_tenths[15:0], pressure_pa[47:16]
    output logic [0:0]  o_m_tuser,   // div_error[0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);

    logic [47:0] r_cal_as;
    logic [47:0] r_cal_au;
    logic [31:0] r_cal_b;
    logic [31:0] r_cal_m;
    logic [1:0]  r_oss;

    logic        w_ce;
    logic [15:0] w_ac1, w_ac2, w_ac3, w_ac4, w_ac5, w_ac6;
    logic [15:0] w_b1, w_b2, w_mc, w_md;

    assign o_cfg_ready = 1'b1;
    assign w_ac1 = r_cal_as[47:32];
    assign w_ac2 = r_cal_as[31:16];
    assign w_ac3 = r_cal_as[15:0];
    assign w_ac4 = r_cal_au[47:32];
    assign w_ac5 = r_cal_au[31:16];
    assign w_ac6 = r_cal_au[15:0];
    assign w_b1  = r_cal_b[31:16];
    assign w_b2  = r_cal_b[15:0];
    assign w_mc  = r_cal_m[31:16];
    assign w_md  = r_cal_m[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_as <= '0;
            r_cal_au <= '0;
            r_cal_b  <= '0;
            r_cal_m  <= '0;
            r_oss    <= 2'd3;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bpc_pkg::CFG_CAL_A_SIGNED:   r_cal_as <= i_cfg_data;
                bpc_pkg::CFG_CAL_A_UNSIGNED: r_cal_au <= i_cfg_data;
                bpc_pkg::CFG_CAL_B_PAIR:     r_cal_b  <= i_cfg_data[31:0];
                bpc_pkg::CFG_CAL_M_PAIR:     r_cal_m  <= i_cfg_data[31:0];
                bpc_pkg::CFG_OVERSAMPLING:   r_oss    <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_s_tready = w_ce;

    // Temperature front end.
    logic        r_a_v, r_b_v, r_c_v, r_d_v;
    logic [16:0] r_a_d;
    logic [18:0] r_a_up, r_b_up, r_c_up, r_d_up;
    logic [31:0] r_b_x1, r_c_x1, r_d_x1, r_c_den;
    logic [26:0] r_d_nmag;
    logic [31:0] r_d_dmag;
    logic        r_d_neg, r_d_dz;

    logic [31:0] w_b_prod;
    logic [15:0] w_d_mcmag;

    assign w_b_prod  = {{15{r_a_d[16]}}, r_a_d} * {16'd0, w_ac5};
    assign w_d_mcmag = w_mc[15] ? 16'(-w_mc) : w_mc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else if (w_ce) begin
            r_a_v <= i_s_tvalid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_a_d    <= {1'b0, i_s_tdata[15:0]} - {1'b0, w_ac6};
            r_a_up   <= i_s_tdata[34:16];
            r_b_x1   <= 32'($signed(w_b_prod) >>> 15);
            r_b_up   <= r_a_up;
            r_c_den  <= r_b_x1 + bpc_pkg::sx16(w_md);
            r_c_x1   <= r_b_x1;
            r_c_up   <= r_b_up;
            r_d_nmag <= {w_d_mcmag, 11'd0};
            r_d_dmag <= r_c_den[31] ? 32'(-r_c_den) : r_c_den;
            r_d_neg  <= w_mc[15] ^ r_c_den[31];
            r_d_dz   <= (r_c_den == 32'd0);
            r_d_x1   <= r_c_x1;
            r_d_up   <= r_c_up;
        end
    end

    localparam int P1W = 53;
    logic           w_q1_v;
    logic [26:0]    w_q1;
    logic [P1W-1:0] w_q1_pay;

    bpc_div #(.NW(27), .DW(32), .PW(P1W)) u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (r_d_v),
        .i_num   (r_d_nmag),
        .i_den   (r_d_dmag),
        .i_pay   ({r_d_neg, r_d_dz, r_d_x1, r_d_up}),
        .o_valid (w_q1_v),
        .o_quo   (w_q1),
        .o_pay   (w_q1_pay)
    );

    // Pressure coefficients.
    logic        w_q1_neg, w_q1_dz;
    logic [31:0] w_q1_x1;
    logic [18:0] w_q1_up;
    assign {w_q1_neg, w_q1_dz, w_q1_x1, w_q1_up} = w_q1_pay;

    logic        r_e_v, r_f_v, r_g_v, r_h_v, r_i_v, r_j_v, r_k_v, r_l_v, r_m_v;
    logic [31:0] r_e_b5, r_f_b6;
    logic [15:0] r_f_t, r_g_t, r_h_t, r_i_t, r_j_t, r_k_t, r_l_t, r_m_t;
    logic        r_e_dz, r_f_dz, r_g_dz, r_h_dz, r_i_dz, r_j_dz, r_k_dz, r_l_dz, r_m_err;
    logic [18:0] r_e_up, r_f_up, r_g_up, r_h_up, r_i_up, r_j_up;
    logic [31:0] r_g_sq, r_g_x2b, r_g_x1c, r_h_x1b, r_h_x2b, r_h_x2c, r_h_x1c;
    logic [31:0] r_i_x3b, r_i_x3cp, r_j_b3, r_j_uc, r_k_b4, r_k_diff;
    logic [31:0] r_l_b7, r_l_b4, r_m_num, r_m_b4;
    logic        r_m_dbl;

    logic [31:0] w_e_q;
    logic [31:0] w_f_t;
    logic [31:0] w_g_m0, w_g_m1, w_g_m2, w_h_m0, w_h_m1;
    logic [31:0] w_j_s, w_j_sh;
    logic [31:0] w_k_prod;
    logic [15:0] w_l_scale;
    logic [31:0] w_l_prod;

    assign w_e_q     = {5'd0, w_q1};
    assign w_f_t     = 32'($signed(r_e_b5 + 32'd8) >>> 4);
    assign w_g_m0    = r_f_b6 * r_f_b6;
    assign w_g_m1    = bpc_pkg::sx16(w_ac2) * r_f_b6;
    assign w_g_m2    = bpc_pkg::sx16(w_ac3) * r_f_b6;
    assign w_h_m0    = bpc_pkg::sx16(w_b2) * r_g_sq;
    assign w_h_m1    = bpc_pkg::sx16(w_b1) * r_g_sq;
    assign w_j_s     = {{14{w_ac1[15]}}, w_ac1, 2'b00} + r_i_x3b;
    assign w_j_sh    = w_j_s << r_oss;
    assign w_k_prod  = {16'd0, w_ac4} * r_j_uc;
    assign w_l_scale = bpc_pkg::C_P_SCALE >> r_oss;
    assign w_l_prod  = r_k_diff * {16'd0, w_l_scale};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
            r_h_v <= 1'b0;
            r_i_v <= 1'b0;
            r_j_v <= 1'b0;
            r_k_v <= 1'b0;
            r_l_v <= 1'b0;
            r_m_v <= 1'b0;
        end else if (w_ce) begin
            r_e_v <= w_q1_v;
            r_f_v <= r_e_v;
            r_g_v <= r_f_v;
            r_h_v <= r_g_v;
            r_i_v <= r_h_v;
            r_j_v <= r_i_v;
            r_k_v <= r_j_v;
            r_l_v <= r_k_v;
            r_m_v <= r_l_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_e_b5   <= w_q1_neg ? (w_q1_x1 - w_e_q) : (w_q1_x1 + w_e_q);
            r_e_dz   <= w_q1_dz;
            r_e_up   <= w_q1_up;

            r_f_t    <= w_f_t[15:0];
            r_f_b6   <= r_e_b5 - bpc_pkg::C_B6_OFFSET;
            r_f_dz   <= r_e_dz;
            r_f_up   <= r_e_up;

            r_g_sq   <= 32'($signed(w_g_m0) >>> 12);
            r_g_x2b  <= 32'($signed(w_g_m1) >>> 11);
            r_g_x1c  <= 32'($signed(w_g_m2) >>> 13);
            r_g_t    <= r_f_t;
            r_g_dz   <= r_f_dz;
            r_g_up   <= r_f_up;

            r_h_x1b  <= 32'($signed(w_h_m0) >>> 11);
            r_h_x2c  <= 32'($signed(w_h_m1) >>> 16);
            r_h_x2b  <= r_g_x2b;
            r_h_x1c  <= r_g_x1c;
            r_h_t    <= r_g_t;
            r_h_dz   <= r_g_dz;
            r_h_up   <= r_g_up;

            r_i_x3b  <= r_h_x1b + r_h_x2b;
            r_i_x3cp <= r_h_x1c + r_h_x2c + 32'd2;
            r_i_t    <= r_h_t;
            r_i_dz   <= r_h_dz;
            r_i_up   <= r_h_up;

            r_j_b3   <= 32'($signed(w_j_sh + 32'd2) >>> 2);
            r_j_uc   <= 32'($signed(r_i_x3cp) >>> 2) + bpc_pkg::C_B4_BIAS;
            r_j_t    <= r_i_t;
            r_j_dz   <= r_i_dz;
            r_j_up   <= r_i_up;

            r_k_b4   <= {15'd0, w_k_prod[31:15]};
            r_k_diff <= {13'd0, r_j_up} - r_j_b3;
            r_k_t    <= r_j_t;
            r_k_dz   <= r_j_dz;

            r_l_b7   <= w_l_prod;
            r_l_b4   <= r_k_b4;
            r_l_t    <= r_k_t;
            r_l_dz   <= r_k_dz || (r_k_b4 == 32'd0);

            r_m_num  <= r_l_b7[31] ? r_l_b7 : {r_l_b7[30:0], 1'b0};
            r_m_dbl  <= r_l_b7[31];
            r_m_b4   <= r_l_b4;
            r_m_t    <= r_l_t;
            r_m_err  <= r_l_dz;
        end
    end

    localparam int P2W = 18;
    logic           w_q2_v;
    logic [31:0]    w_q2;
    logic [P2W-1:0] w_q2_pay;

    bpc_div #(.NW(32), .DW(32), .PW(P2W)) u_div_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (r_m_v),
        .i_num   (r_m_num),
        .i_den   (r_m_b4),
        .i_pay   ({r_m_t, r_m_err, r_m_dbl}),
        .o_valid (w_q2_v),
        .o_quo   (w_q2),
        .o_pay   (w_q2_pay)
    );

    // Final pressure polynomial.
    logic [15:0] w_q2_t;
    logic        w_q2_err, w_q2_dbl;
    assign {w_q2_t, w_q2_err, w_q2_dbl} = w_q2_pay;

    logic        r_n_v, r_o_v, r_p_v, r_q_v;
    logic [31:0] r_n_p, r_o_p, r_p_p;
    logic [31:0] r_o_sqp, r_o_x2d, r_p_x1d, r_p_x2d;
    logic [15:0] r_n_t, r_o_t, r_p_t;
    logic        r_n_err, r_o_err, r_p_err;
    bpc_pkg::t_result r_q_res;

    logic [31:0] w_o_pa, w_o_m0, w_o_m1, w_p_m0, w_q_sum, w_q_p;

    assign w_o_pa  = 32'($signed(r_n_p) >>> 8);
    assign w_o_m0  = w_o_pa * w_o_pa;
    assign w_o_m1  = bpc_pkg::C_P_C2 * r_n_p;
    assign w_p_m0  = r_o_sqp * bpc_pkg::C_P_C1;
    assign w_q_sum = r_p_x1d + r_p_x2d + bpc_pkg::C_P_C3;
    assign w_q_p   = r_p_p + 32'($signed(w_q_sum) >>> 4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_v <= 1'b0;
            r_o_v <= 1'b0;
            r_p_v <= 1'b0;
            r_q_v <= 1'b0;
        end else if (w_ce) begin
            r_n_v <= w_q2_v;
            r_o_v <= r_n_v;
            r_p_v <= r_o_v;
            r_q_v <= r_p_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_n_p   <= w_q2_dbl ? {w_q2[30:0], 1'b0} : w_q2;
            r_n_t   <= w_q2_t;
            r_n_err <= w_q2_err;

            r_o_sqp <= w_o_m0;
            r_o_x2d <= 32'($signed(w_o_m1) >>> 16);
            r_o_p   <= r_n_p;
            r_o_t   <= r_n_t;
            r_o_err <= r_n_err;

            r_p_x1d <= 32'($signed(w_p_m0) >>> 16);
            r_p_x2d <= r_o_x2d;
            r_p_p   <= r_o_p;
            r_p_t   <= r_o_t;
            r_p_err <= r_o_err;

            r_q_res.div_error   <= r_p_err;
            r_q_res.pressure_pa <= r_p_err ? 32'd0 : w_q_p;
            r_q_res.temp_tenths <= r_p_err ? 16'd0 : r_p_t;
        end
    end

    bpc_pkg::t_result w_out;

    bpc_obuf u_obuf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (r_q_v),
        .i_res     (r_q_res),
        .o_ce      (w_ce),
        .o_valid   (o_m_tvalid),
        .o_res     (w_out),
        .i_m_ready (i_m_tready)
    );

    assign o_m_tdata = {w_out.pressure_pa, w_out.temp_tenths};
    assign o_m_tuser = w_out.div_error;

endmodule

@@ src/bpc_div.sv @@
// ============================================================================
// Pipelined unsigned divider
// Restoring division, one quotient bit per register stage, with side data.
// ============================================================================
module bpc_div #(
    parameter int NW = 32,
    parameter int DW = 32,
    parameter int PW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_ce,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [NW-1:0] o_quo,
    output logic [PW-1:0] o_pay
);

    logic          w_v   [0:NW-1];
    logic [NW-1:0] w_nq  [0:NW-1];
    logic [DW-1:0] w_rem [0:NW-1];
    logic [DW-1:0] w_den [0:NW-1];
    logic [PW-1:0] w_pay [0:NW-1];

    logic          r_v   [1:NW];
    logic [NW-1:0] r_nq  [1:NW];
    logic [DW-1:0] r_rem [1:NW];
    logic [DW-1:0] r_den [1:NW];
    logic [PW-1:0] r_pay [1:NW];

    genvar k;
    for (k = 0; k < NW; k++) begin : g_stage
        logic [DW:0] w_try;
        logic [DW:0] w_sub;
        logic        w_ge;

        if (k == 0) begin : g_src_in
            assign w_v[k]   = i_valid;
            assign w_nq[k]  = i_num;
            assign w_rem[k] = '0;
            assign w_den[k] = i_den;
            assign w_pay[k] = i_pay;
        end else begin : g_src_reg
            assign w_v[k]   = r_v[k];
            assign w_nq[k]  = r_nq[k];
            assign w_rem[k] = r_rem[k];
            assign w_den[k] = r_den[k];
            assign w_pay[k] = r_pay[k];
        end

        assign w_try = {w_rem[k], w_nq[k][NW-1]};
        assign w_sub = w_try - {1'b0, w_den[k]};
        assign w_ge  = (w_try >= {1'b0, w_den[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_ce) begin
                r_v[k+1] <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[k+1] <= w_ge ? w_sub[DW-1:0] : w_try[DW-1:0];
                r_nq[k+1]  <= {w_nq[k][NW-2:0], w_ge};
                r_den[k+1] <= w_den[k];
                r_pay[k+1] <= w_pay[k];
            end
        end
    end

    assign o_valid = r_v[NW];
    assign o_quo   = r_nq[NW];
    assign o_pay   = r_pay[NW];

endmodule

@@ src/bpc_obuf.sv @@
// ============================================================================
// Output register with skid stage
// Holds results for the master side and stalls the pipeline when both fill.
// ============================================================================
`include "barometric_pressure_compensation_assert.svh"

module bpc_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bpc_pkg::t_result  i_res,
    output logic              o_ce,
    output logic              o_valid,
    output bpc_pkg::t_result  o_res,
    input  logic              i_m_ready
);

    logic             r_out_v;
    logic             r_skid_v;
    bpc_pkg::t_result r_out;
    bpc_pkg::t_result r_skid;
    logic             w_push;
    logic             w_free;

    assign o_ce    = !r_skid_v;
    assign w_push  = i_push && !r_skid_v;
    assign w_free  = !r_out_v || i_m_ready;
    assign o_valid = r_out_v;
    assign o_res   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_free) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (w_free) begin
            r_out_v <= w_push;
        end else if (w_push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_free) begin
                r_out <= r_skid;
            end
        end else if (w_free) begin
            if (w_push) begin
                r_out <= i_res;
            end
        end else if (w_push) begin
            r_skid <= i_res;
        end
    end

    `BPC_ASSERT(a_skid_behind_out, i_clk, i_rst_n, r_skid_v |-> r_out_v)
    `BPC_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (!r_out_v && !r_skid_v))
    `BPC_ASSERT(a_stall_to_skid, i_clk, i_rst_n,
        (r_out_v && !i_m_ready && !r_skid_v && i_push) |=> r_skid_v)
    `BPC_ASSERT(a_skid_drains, i_clk, i_rst_n,
        (r_skid_v && i_m_ready) |=> (r_out_v && !r_skid_v))

endmodule

@@ verif/tb_barometric_pressure_compensation.sv @@
// ----------------------------------------------------------------------------
// Testbench for the barometric pressure compensation block
// Drives raw temperature and pressure words through the input stream under
// several calibration sets, predicts each compensated result in the
// testbench and compares it field by field with the output stream.
// ----------------------------------------------------------------------------
module tb_barometric_pressure_compensation;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] temp_tenths;
        logic [31:0] pressure_pa;
        logic        div_error;
    } t_expect;

    localparam int LATENCY = 77;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;
    logic [0:0]  o_m_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [47:0] i_cfg_data = '0;

    logic [47:0] cal_acs;
    logic [47:0] cal_acu;
    logic [31:0] cal_b;
    logic [31:0] cal_m;
    logic [1:0]  oss_set;

    t_expect     pending_results[$];
    int          error_count = 0;
    bit          rx_active = 1'b0;

    barometric_pressure_compensation i_dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #300ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic signed [31:0] sw16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic t_expect compensate(input logic [15:0] ut, input logic [18:0] up);
        t_expect r;
        logic signed [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic signed [31:0] x1, x2, x3, b3, b5, b6, sq, p, t, den;
        logic signed [63:0] quot;
        logic [31:0] b4, b7, q;
        logic [63:0] wide;
        ac1 = sw16(cal_acs[47:32]);
        ac2 = sw16(cal_acs[31:16]);
        ac3 = sw16(cal_acs[15:0]);
        ac4 = {16'd0, cal_acu[47:32]};
        ac5 = {16'd0, cal_acu[31:16]};
        ac6 = {16'd0, cal_acu[15:0]};
        b1 = sw16(cal_b[31:16]);
        b2 = sw16(cal_b[15:0]);
        mc = sw16(cal_m[31:16]);
        md = sw16(cal_m[15:0]);
        r.temp_tenths = '0;
        r.pressure_pa = '0;
        r.div_error = 1'b1;
        x1 = (($signed({16'd0, ut}) - ac6) * ac5) >>> 15;
        den = x1 + md;
        if (den == 0) return r;
        quot = (64'(mc) * 64'sd2048) / 64'(den);
        x2 = quot[31:0];
        b5 = x1 + x2;
        t = (b5 + 8) >>> 4;
        b6 = b5 - 4000;
        sq = (b6 * b6) >>> 12;
        x1 = (b2 * sq) >>> 11;
        x2 = (ac2 * b6) >>> 11;
        x3 = x1 + x2;
        b3 = ((((ac1 * 4) + x3) << oss_set) + 2) >>> 2;
        x1 = (ac3 * b6) >>> 13;
        x2 = (b1 * sq) >>> 16;
        x3 = (x1 + x2 + 2) >>> 2;
        wide = 64'(unsigned'(ac4)) * 64'(32'(unsigned'(x3) + 32'd32768));
        b4 = wide[31:0] >> 15;
        if (b4 == 0) return r;
        b7 = (32'({13'd0, up}) - unsigned'(b3)) * (32'd50000 >> oss_set);
        if (b7 < 32'h8000_0000) q = (b7 << 1) / b4;
        else q = (b7 / b4) << 1;
        p = signed'(q);
        x1 = (p >>> 8) * (p >>> 8);
        x1 = (x1 * 3038) >>> 16;
        x2 = (-32'sd7357 * p) >>> 16;
        p = p + ((x1 + x2 + 3791) >>> 4);
        r.temp_tenths = t[15:0];
        r.pressure_pa = p;
        r.div_error = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("Mismatch in %s: got %h, expected %h", what, got, want);
        error_count++;
    endtask

    task automatic write_reg(input bpc_pkg::t_cfg_idx idx, input logic [47:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            bpc_pkg::CFG_CAL_A_SIGNED:   cal_acs = data;
            bpc_pkg::CFG_CAL_A_UNSIGNED: cal_acu = data;
            bpc_pkg::CFG_CAL_B_PAIR:     cal_b = data[31:0];
            bpc_pkg::CFG_CAL_M_PAIR:     cal_m = data[31:0];
            default:                     oss_set = data[1:0];
        endcase
    endtask

    task automatic send_sample(input logic [15:0] ut, input logic [18:0] up);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {5'd0, up, ut};
        do @(posedge i_clk); while (!o_s_tready);
        pending_results.push_back(compensate(ut, up));
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    // Typical sensor calibration, so that most samples land in a sane range.
    task automatic load_typical(input logic [1:0] oss);
        write_reg(bpc_pkg::CFG_CAL_A_SIGNED, {16'd408, -16'sd72, -16'sd14383});
        write_reg(bpc_pkg::CFG_CAL_A_UNSIGNED, {16'd32741, 16'd32757, 16'd23153});
        write_reg(bpc_pkg::CFG_CAL_B_PAIR, {16'd0, 16'd6190, 16'd4});
        write_reg(bpc_pkg::CFG_CAL_M_PAIR, {16'd0, -16'sd8711, 16'd2868});
        write_reg(bpc_pkg::CFG_OVERSAMPLING, {46'd0, oss});
    endtask

    task automatic test_directed();
        load_typical(2'd0);
        send_sample(16'd27898, 19'd23843);
        send_sample(16'd0, 19'd0);
        send_sample(16'hFFFF, 19'h7FFFF);
        send_sample(16'h8000, 19'h40000);
        send_sample(16'd27898, 19'h7FFFF);
        drain();
        write_reg(bpc_pkg::CFG_OVERSAMPLING, 48'd3);
        send_sample(16'd27898, 19'd190000);
        send_sample(16'hFFFF, 19'd0);
        drain();
        // Zero temperature divisor: x1 is zero when ut equals ac6, and md is zero.
        write_reg(bpc_pkg::CFG_CAL_M_PAIR, {16'd0, 16'd100, 16'd0});
        send_sample(16'd23153, 19'd1000);
        drain();
        // Zero pressure divisor: ac4 of zero.
        write_reg(bpc_pkg::CFG_CAL_A_UNSIGNED, {16'd0, 16'd32757, 16'd23153});
        send_sample(16'd27898, 19'd23843);
        drain();
        write_reg(bpc_pkg::CFG_CAL_A_SIGNED, 48'hFFFF_FFFF_FFFF);
        write_reg(bpc_pkg::CFG_CAL_A_UNSIGNED, 48'hFFFF_FFFF_FFFF);
        write_reg(bpc_pkg::CFG_CAL_B_PAIR, 48'hFFFF_FFFF);
        write_reg(bpc_pkg::CFG_CAL_M_PAIR, 48'h7FFF_8000);
        send_sample(16'd0, 19'h7FFFF);
        send_sample(16'hFFFF, 19'd0);
        send_sample(16'h1234, 19'h2AAAA);
        drain();
        write_reg(bpc_pkg::CFG_CAL_A_SIGNED, 48'h8000_8000_8000);
        write_reg(bpc_pkg::CFG_CAL_A_UNSIGNED, 48'h0001_0000_FFFF);
        write_reg(bpc_pkg::CFG_CAL_B_PAIR, 48'h7FFF_7FFF);
        write_reg(bpc_pkg::CFG_CAL_M_PAIR, 48'h8000_7FFF);
        write_reg(bpc_pkg::CFG_OVERSAMPLING, 48'd1);
        send_sample(16'hFFFF, 19'h7FFFF);
        send_sample(16'd0, 19'd1);
        send_sample(16'h7FFF, 19'h55555);
        drain();
    endtask

    task automatic test_random_calibration();
        for (int phase = 0; phase < 6; phase++) begin
            if (phase < 3) begin
                load_typical(2'($urandom_range(0, 3)));
            end else begin
                write_reg(bpc_pkg::CFG_CAL_A_SIGNED, 48'({$urandom(), $urandom()}));
                write_reg(bpc_pkg::CFG_CAL_A_UNSIGNED, 48'({$urandom(), $urandom()}));
                write_reg(bpc_pkg::CFG_CAL_B_PAIR, {16'd0, $urandom()});
                write_reg(bpc_pkg::CFG_CAL_M_PAIR, {16'd0, $urandom()});
                write_reg(bpc_pkg::CFG_OVERSAMPLING, 48'($urandom_range(0, 3)));
            end
            for (int n = 0; n < 80; n++) begin
                if (phase < 3 && $urandom_range(0, 3) != 0)
                    send_sample(16'($urandom_range(20000, 34000)),
                                19'($urandom_range(20000, 400000)));
                else
                    send_sample(16'($urandom()), 19'($urandom()));
                if (n == 40) drain();
            end
            drain();
        end
    endtask

    initial begin
        cal_acs = '0;
        cal_acu = '0;
        cal_b = '0;
        cal_m = '0;
        oss_set = 2'd3;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        rx_active = 1'b1;
        test_directed();
        test_random_calibration();
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        int stall;
        forever begin
            @(posedge i_clk);
            if (rx_active) begin
                stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
                if (stall != 0) begin
                    i_m_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                i_m_tready <= 1'b1;
                do @(posedge i_clk); while (!o_m_tvalid);
                i_m_tready <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_expect want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", {16'd0, o_m_tdata[15:0]}, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata[15:0] !== want.temp_tenths)
                    report_mismatch("temp_tenths", {16'd0, o_m_tdata[15:0]},
                                    {16'd0, want.temp_tenths});
                if (o_m_tdata[47:16] !== want.pressure_pa)
                    report_mismatch("pressure_pa", o_m_tdata[47:16], want.pressure_pa);
                if (o_m_tuser[0] !== want.div_error)
                    report_mismatch("div_error", {31'd0, o_m_tuser[0]},
                                    {31'd0, want.div_error});
            end
        end
    end
endmodule

@@ sim.f @@
+incdir+src
src/bpc_pkg.sv
src/bpc_div.sv
src/bpc_obuf.sv
src/barometric_pressure_compensation.sv
verif/tb_barometric_pressure_compensation.sv
